FILE: rtl/core/uv_sphere_mesh_generator_top_macros.svh
// Assertion shorthands for the UV sphere generator checker.
`ifndef UV_SPHERE_MESH_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define UVS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/uvs_pkg.sv
package uvs_pkg;

    localparam int MAX_SEGMENTS     = 255;
    localparam int MIN_SEGMENTS     = 2;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int SINE_AW   = $clog2(SINE_TABLE_DEPTH);
    localparam int QDEPTH    = SINE_TABLE_DEPTH / 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int PHASE_W   = 17;
    localparam int IDX_SHIFT = PHASE_W - SINE_AW;
    localparam int IDX_HALF  = 1 << (IDX_SHIFT - 1);

    localparam logic [PHASE_W-1:0] PHASE_QUARTER = 17'd32768;

    localparam int PIPE_STAGES = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SEGMENT_COUNT = 2'd0,
        REG_SECTOR_STEP   = 2'd1,
        REG_SPHERE_RADIUS = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_TRI    = 2'd1,
        KIND_ERR    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REQ_VERTEX = 2'd0,
        REQ_CELL   = 2'd1,
        REQ_ERROR  = 2'd2
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
        logic has1;
        logic has2;
    } stage_ctl_t;

    typedef logic [QDEPTH-1:0][14:0] qtab_t;

    // sin(pi/2 * t), t in Q30 over [0, 1], result Q14
    function automatic logic [14:0] quarter_sine(input longint unsigned t);
        longint unsigned t2;
        longint unsigned p;
        longint unsigned s;
        t2 = (t * t) >> 30;
        p  = 64'd172272;
        p  = 64'd5026996 - ((t2 * p) >> 30);
        p  = 64'd85569306 - ((t2 * p) >> 30);
        p  = 64'd693598670 - ((t2 * p) >> 30);
        p  = 64'd1686629713 - ((t2 * p) >> 30);
        s  = (t * p) >> 30;
        s  = (s + 64'd32768) >> 16;
        if (s > 64'd16384)
        begin
            s = 64'd16384;
        end
        return s[14:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t           tab;
        longint unsigned t;
        for (int m = 0; m < QDEPTH; m++)
        begin
            t      = longint'(m) << (30 - QAW);
            tab[m] = quarter_sine(t);
        end
        return tab;
    endfunction

    localparam qtab_t      QTAB = build_qtab();
    localparam logic [14:0] QTOP = quarter_sine(64'd1 << 30);

    function automatic logic [SINE_AW-1:0] phase_index(input logic [PHASE_W-1:0] p);
        logic [PHASE_W:0] sum;
        sum = {1'b0, p} + (PHASE_W + 1)'(IDX_HALF);
        return sum[IDX_SHIFT +: SINE_AW];
    endfunction

    // full wave from the quarter table by symmetry
    function automatic logic signed [15:0] sine_lookup(input logic [SINE_AW-1:0] idx);
        logic [1:0]     quad;
        logic [QAW-1:0] m;
        logic [QAW-1:0] mref;
        logic [14:0]    mag;
        quad = idx[SINE_AW-1 -: 2];
        m    = idx[QAW-1:0];
        mref = quad[0] ? (QAW'(~m) + QAW'(1)) : m;
        mag  = (quad[0] && (m == '0)) ? QTOP : QTAB[mref];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // rounds half away from zero
    function automatic logic signed [47:0] round_away(input logic signed [47:0] v,
                                                      input int unsigned sh);
        logic [47:0] mag;
        logic [47:0] half;
        half = 48'd1 << (sh - 1);
        mag  = v[47] ? 48'(-v) : 48'(v);
        mag  = (mag + half) >> sh;
        return v[47] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

FILE: rtl/core/uv_sphere_mesh_generator_top.sv
// A request passes through the pipeline stages and the output register
// before its result is presented. Throughput: one request per cycle while
// req_stall is low; a two-triangle cell stalls requests until both issue.
// Reset: asynchronous, empties the pipeline and loads the register defaults
// (16 segments, step 4096, radius 256); the sine table is constant logic.
module uv_sphere_mesh_generator_top
    import uvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     func,
    input  logic [7:0]               stack_index,
    input  logic [7:0]               sector_index,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [1:0]               kind,
    output logic signed [17:0]       pos_x,
    output logic signed [17:0]       pos_y,
    output logic signed [17:0]       pos_z,
    output logic signed [15:0]       norm_x,
    output logic signed [15:0]       norm_y,
    output logic signed [15:0]       norm_z,
    output logic [15:0]              corner_a,
    output logic [15:0]              corner_b,
    output logic [15:0]              corner_c,
    output logic                     last
);

    localparam int LS = PIPE_STAGES - 1;

    logic [7:0]  seg_count_reg;
    logic [15:0] sector_step_reg;
    logic [15:0] radius_reg;

    logic [7:0]  n_eff;
    logic [8:0]  n_plus;

    stage_ctl_t  ctl_reg [PIPE_STAGES];
    logic [15:0] k1_reg  [PIPE_STAGES];
    logic [15:0] k2_reg  [1:LS];

    // stage 0
    stage_ctl_t          ctl0_next;
    logic [PHASE_W-1:0]  ist_full;
    logic [PHASE_W-2:0]  jst_full;
    logic [PHASE_W-1:0]  ist_reg, ist_next;
    logic [PHASE_W-1:0]  jst_reg, jst_next;
    logic [15:0]         k1_next;
    logic                req_err;

    // stage 1
    logic [PHASE_W-1:0]  up_phase;
    logic [SINE_AW-1:0]  idx_su_reg, idx_su_next;
    logic [SINE_AW-1:0]  idx_cu_reg, idx_cu_next;
    logic [SINE_AW-1:0]  idx_sv_reg, idx_sv_next;
    logic [SINE_AW-1:0]  idx_cv_reg, idx_cv_next;
    logic [15:0]         k2_next;

    // stage 2
    logic signed [15:0]  su2_reg, cu2_reg, sv2_reg, cv2_reg;

    // stage 3
    logic signed [31:0]  pcc_reg, pcc_next;
    logic signed [31:0]  pcs_reg, pcs_next;
    logic signed [33:0]  prz_reg, prz_next;
    logic signed [15:0]  su3_reg;

    // stage 4
    logic signed [47:0]  fx_reg, fx_next;
    logic signed [47:0]  fy_reg, fy_next;
    logic signed [17:0]  pz4_reg, pz4_next;
    logic signed [15:0]  nx4_reg, nx4_next;
    logic signed [15:0]  ny4_reg, ny4_next;
    logic signed [15:0]  nz4_reg;

    // stage 5
    logic signed [17:0]  px_reg, px_next;
    logic signed [17:0]  py_reg, py_next;
    logic signed [17:0]  pz5_reg;
    logic signed [15:0]  nx5_reg, ny5_reg, nz5_reg;

    // output
    logic                out_valid_reg;
    logic                sec_reg;
    kind_t               kind_reg, kind_next;
    logic signed [17:0]  pos_x_reg, pos_x_next;
    logic signed [17:0]  pos_y_reg, pos_y_next;
    logic signed [17:0]  pos_z_reg, pos_z_next;
    logic signed [15:0]  norm_x_reg, norm_x_next;
    logic signed [15:0]  norm_y_reg, norm_y_next;
    logic signed [15:0]  norm_z_reg, norm_z_next;
    logic [15:0]         corner_a_reg, corner_a_next;
    logic [15:0]         corner_b_reg, corner_b_next;
    logic [15:0]         corner_c_reg, corner_c_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                item_done;
    logic                second_tri;
    logic                adv;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg   <= 8'd16;
            sector_step_reg <= 16'd4096;
            radius_reg      <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEGMENT_COUNT: seg_count_reg   <= cfg_data[7:0];
                REG_SECTOR_STEP:   sector_step_reg <= cfg_data;
                REG_SPHERE_RADIUS: radius_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (seg_count_reg < 8'(MIN_SEGMENTS))
        begin
            n_eff = 8'(MIN_SEGMENTS);
        end
        else if (seg_count_reg > 8'(MAX_SEGMENTS))
        begin
            n_eff = 8'(MAX_SEGMENTS);
        end
        else
        begin
            n_eff = seg_count_reg;
        end
        n_plus = {1'b0, n_eff} + 9'd1;
    end

    // stage 0: range check, angle products, first cell index
    always_comb
    begin
        if (func)
        begin
            req_err = (stack_index >= n_eff) || (sector_index >= n_eff);
        end
        else
        begin
            req_err = (stack_index > n_eff) || (sector_index > n_eff);
        end
        ctl0_next.valid = req_valid;
        ctl0_next.has1  = (stack_index != 8'd0);
        ctl0_next.has2  = (stack_index != 8'(n_eff - 8'd1));
        if (req_err)
        begin
            ctl0_next.req = REQ_ERROR;
        end
        else if (func)
        begin
            ctl0_next.req = REQ_CELL;
        end
        else
        begin
            ctl0_next.req = REQ_VERTEX;
        end
        ist_full = PHASE_W'(stack_index) * PHASE_W'(sector_step_reg);
        jst_full = (PHASE_W-1)'(sector_index) * sector_step_reg;
        ist_next = ist_full;
        jst_next = {jst_full, 1'b0};
        k1_next  = 16'(stack_index) * 16'(n_plus) + 16'(sector_index);
    end

    // stage 1: phases to table indices, second cell index
    always_comb
    begin
        up_phase    = PHASE_QUARTER - ist_reg;
        idx_su_next = phase_index(up_phase);
        idx_cu_next = phase_index(up_phase + PHASE_QUARTER);
        idx_sv_next = phase_index(jst_reg);
        idx_cv_next = phase_index(jst_reg + PHASE_QUARTER);
        k2_next     = k1_reg[0] + 16'(n_plus);
    end

    // stage 3: angle products, radius times the up sine
    always_comb
    begin
        pcc_next = 32'(cu2_reg) * 32'(cv2_reg);
        pcs_next = 32'(cu2_reg) * 32'(sv2_reg);
        prz_next = 34'($signed({1'b0, radius_reg})) * 34'(su2_reg);
    end

    // stage 4: radius scaling, normal and z position rounding
    always_comb
    begin
        fx_next  = 48'($signed({1'b0, radius_reg})) * 48'(pcc_reg);
        fy_next  = 48'($signed({1'b0, radius_reg})) * 48'(pcs_reg);
        nx4_next = 16'(round_away(48'(pcc_reg), 14));
        ny4_next = 16'(round_away(48'(pcs_reg), 14));
        pz4_next = 18'(round_away(48'(prz_reg), 14));
    end

    // stage 5: position rounding
    always_comb
    begin
        px_next = 18'(round_away(fx_reg, 28));
        py_next = 18'(round_away(fy_reg, 28));
    end

    // output selection
    always_comb
    begin
        out_free   = !out_valid_reg || !res_stall;
        item_done  = 1'b1;
        second_tri = !ctl_reg[LS].has1 || sec_reg;
        if ((ctl_reg[LS].req == REQ_CELL) && ctl_reg[LS].has1 && ctl_reg[LS].has2
            && !sec_reg)
        begin
            item_done = 1'b0;
        end
        adv = !ctl_reg[LS].valid || (out_free && item_done);

        kind_next     = KIND_ERR;
        pos_x_next    = '0;
        pos_y_next    = '0;
        pos_z_next    = '0;
        norm_x_next   = '0;
        norm_y_next   = '0;
        norm_z_next   = '0;
        corner_a_next = '0;
        corner_b_next = '0;
        corner_c_next = '0;
        last_next     = 1'b1;
        case (ctl_reg[LS].req)
            REQ_VERTEX:
            begin
                kind_next   = KIND_VERTEX;
                pos_x_next  = px_reg;
                pos_y_next  = py_reg;
                pos_z_next  = pz5_reg;
                norm_x_next = nx5_reg;
                norm_y_next = ny5_reg;
                norm_z_next = nz5_reg;
            end
            REQ_CELL:
            begin
                kind_next     = KIND_TRI;
                last_next     = item_done;
                corner_b_next = k2_reg[LS];
                if (second_tri)
                begin
                    corner_a_next = k1_reg[LS] + 16'd1;
                    corner_c_next = k2_reg[LS] + 16'd1;
                end
                else
                begin
                    corner_a_next = k1_reg[LS];
                    corner_c_next = k1_reg[LS] + 16'd1;
                end
            end
            default:
            begin
                kind_next = KIND_ERR;
            end
        endcase
    end

    assign req_stall = !adv;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE_STAGES; s++)
            begin
                ctl_reg[s] <= '0;
            end
            out_valid_reg <= 1'b0;
            sec_reg       <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                ctl_reg[0] <= ctl0_next;
                for (int s = 1; s < PIPE_STAGES; s++)
                begin
                    ctl_reg[s] <= ctl_reg[s-1];
                end
            end
            if (out_free)
            begin
                out_valid_reg <= ctl_reg[LS].valid;
                if (ctl_reg[LS].valid)
                begin
                    sec_reg <= !item_done;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ist_reg    <= ist_next;
            jst_reg    <= jst_next;
            k1_reg[0]  <= k1_next;

            idx_su_reg <= idx_su_next;
            idx_cu_reg <= idx_cu_next;
            idx_sv_reg <= idx_sv_next;
            idx_cv_reg <= idx_cv_next;
            k1_reg[1]  <= k1_reg[0];
            k2_reg[1]  <= k2_next;

            su2_reg    <= sine_lookup(idx_su_reg);
            cu2_reg    <= sine_lookup(idx_cu_reg);
            sv2_reg    <= sine_lookup(idx_sv_reg);
            cv2_reg    <= sine_lookup(idx_cv_reg);

            pcc_reg    <= pcc_next;
            pcs_reg    <= pcs_next;
            prz_reg    <= prz_next;
            su3_reg    <= su2_reg;

            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            pz4_reg    <= pz4_next;
            nx4_reg    <= nx4_next;
            ny4_reg    <= ny4_next;
            nz4_reg    <= su3_reg;

            px_reg     <= px_next;
            py_reg     <= py_next;
            pz5_reg    <= pz4_reg;
            nx5_reg    <= nx4_reg;
            ny5_reg    <= ny4_reg;
            nz5_reg    <= nz4_reg;

            for (int s = 2; s < PIPE_STAGES; s++)
            begin
                k1_reg[s] <= k1_reg[s-1];
                k2_reg[s] <= k2_reg[s-1];
            end
        end
        if (out_free && ctl_reg[LS].valid)
        begin
            kind_reg     <= kind_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            norm_x_reg   <= norm_x_next;
            norm_y_reg   <= norm_y_next;
            norm_z_reg   <= norm_z_next;
            corner_a_reg <= corner_a_next;
            corner_b_reg <= corner_b_next;
            corner_c_reg <= corner_c_next;
            last_reg     <= last_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign norm_x    = norm_x_reg;
    assign norm_y    = norm_y_reg;
    assign norm_z    = norm_z_reg;
    assign corner_a  = corner_a_reg;
    assign corner_b  = corner_b_reg;
    assign corner_c  = corner_c_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/core/uvs_checker.sv
`include "uv_sphere_mesh_generator_top_macros.svh"

module uvs_checker
    import uvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     req_valid,
    input  logic                     req_stall,
    input  logic                     func,
    input  logic [7:0]               stack_index,
    input  logic [7:0]               sector_index,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  logic [1:0]               kind,
    input  logic signed [17:0]       pos_x,
    input  logic signed [17:0]       pos_y,
    input  logic signed [17:0]       pos_z,
    input  logic signed [15:0]       norm_x,
    input  logic signed [15:0]       norm_y,
    input  logic signed [15:0]       norm_z,
    input  logic [15:0]              corner_a,
    input  logic [15:0]              corner_b,
    input  logic [15:0]              corner_c,
    input  logic                     last
);

    // stalled result holds
    `UVS_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(kind) && $stable(pos_x) && $stable(corner_a) && $stable(last), "stalled result changed")

    // error result carries nothing else
    `UVS_ASSERT_NOW(a_err_clean, res_valid && kind == KIND_ERR, last && pos_x == 18'sd0 && norm_z == 16'sd0 && corner_a == 16'd0, "error result not clean")

    // first of a triangle pair is followed at once by the closing triangle
    `UVS_ASSERT_NEXT(a_tri_pair, res_valid && !res_stall && kind == KIND_TRI && !last, res_valid && kind == KIND_TRI && last, "triangle pair broken")

    // triangle corners follow the grid pattern
    `UVS_ASSERT_NOW(a_tri_shape, res_valid && kind == KIND_TRI, pos_z == 18'sd0 && (corner_c == 16'(corner_a + 16'd1) || corner_c == 16'(corner_b + 16'd1)), "triangle corners malformed")

endmodule

bind uv_sphere_mesh_generator_top uvs_checker u_checker (.*);
